@@ rtl/core/srbm_pkg.sv @@
package srbm_pkg;

  // Largest ring the descriptor table is built for.
  localparam int unsigned MAX_SLOTS = 16;

  // Fixed field widths.
  localparam int unsigned COUNT_W  = 5;
  localparam int unsigned SIZE_W   = 16;
  localparam int unsigned ADDR_W   = 20;
  localparam int unsigned STREAM_W = 32;
  localparam int unsigned FUNC_W   = 3;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned SLOT_W   = 4;

  // Register reset values.
  localparam logic [COUNT_W-1:0] SLOT_COUNT_RST = 5'd16;
  localparam logic [SIZE_W-1:0]  SLOT_SIZE_RST  = 16'd256;

  // Configuration register indexes.
  localparam logic REG_SLOT_COUNT = 1'b0;
  localparam logic REG_SLOT_SIZE  = 1'b1;

  typedef enum logic [FUNC_W-1:0] {
    FN_ACQUIRE       = 3'd0,
    FN_COMMIT        = 3'd1,
    FN_COMMIT_AT     = 3'd2,
    FN_PEEK          = 3'd3,
    FN_RELEASE       = 3'd4,
    FN_RELEASE_BYTES = 3'd5,
    FN_CLEAR         = 3'd6
  } func_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 3'd0,
    ST_INVALID   = 3'd1,
    ST_FULL      = 3'd2,
    ST_EMPTY     = 3'd3,
    ST_TOO_LARGE = 3'd4
  } status_e;

  // Update request from the execute logic to the descriptor table.
  typedef struct packed {
    logic commit;
    logic release_slot;
    logic clear;
  } desc_cmd_t;

endpackage

@@ rtl/core/srbm_desc_table.sv @@
// Per-slot descriptors. Only the ready flags are reset; offset and length
// are not reset and are written only on commit.
module srbm_desc_table #(
  parameter int unsigned MaxSlots = srbm_pkg::MAX_SLOTS,
  localparam int unsigned IdxW = (MaxSlots > 1) ? $clog2(MaxSlots) : 1
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  srbm_pkg::desc_cmd_t                  cmd_i,
  input  logic [IdxW-1:0]                      wr_idx_i,
  input  logic [srbm_pkg::STREAM_W-1:0]        wr_offset_i,
  input  logic [srbm_pkg::SIZE_W-1:0]          wr_length_i,
  input  logic [IdxW-1:0]                      rd_idx_i,
  output logic                                 rd_ready_o,
  output logic [srbm_pkg::SIZE_W-1:0]          rd_length_o,
  output logic [srbm_pkg::STREAM_W-1:0]        rd_offset_o
);

  logic [MaxSlots-1:0]               ready_q;
  logic [srbm_pkg::STREAM_W-1:0]     offset_q [MaxSlots];
  logic [srbm_pkg::SIZE_W-1:0]       length_q [MaxSlots];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ready_q <= '0;
    end else if (cmd_i.clear) begin
      ready_q <= '0;
    end else begin
      if (cmd_i.commit) begin
        ready_q[wr_idx_i] <= 1'b1;
      end
      if (cmd_i.release_slot) begin
        ready_q[rd_idx_i] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      offset_q[wr_idx_i] <= wr_offset_i;
      length_q[wr_idx_i] <= wr_length_i;
    end
  end

  assign rd_ready_o  = ready_q[rd_idx_i];
  assign rd_length_o = length_q[rd_idx_i];
  assign rd_offset_o = offset_q[rd_idx_i];

endmodule

@@ rtl/core/slot_ring_buffer_manager_unit.sv @@
// Channel   Direction  Handshake                 Payload
// input     in         in_valid_i / in_ready_o   func_i, at_offset_i, byte_count_i
// result    out        out_valid_o / out_ready_i status_o, slot_id_o, buffer_offset_o,
//                                                span_length_o, stream_offset_o,
//                                                ready_count_o, free_count_o
// config    in         cfg_we_i (no wait)        cfg_index_i, cfg_data_i
//
// One operation per cycle is sustained while the result is taken; a transfer passes
// from input to result through the input register and then the result register.
// The operation is executed in a single pass between those two registers.
// Reset is asynchronous: pointers, counts and ready flags clear, the slot count
// returns to 16 and the slot size to 256.
// When the result register is held, a full input register holds too, and the
// input accepts a transfer only while its register is empty or can move on.
module slot_ring_buffer_manager_unit #(
  parameter int unsigned MaxSlots = srbm_pkg::MAX_SLOTS
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // Operation input
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [srbm_pkg::FUNC_W-1:0]       func_i,
  input  logic [srbm_pkg::STREAM_W-1:0]     at_offset_i,
  input  logic [srbm_pkg::SIZE_W-1:0]       byte_count_i,
  // Result output
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [srbm_pkg::STATUS_W-1:0]     status_o,
  output logic [srbm_pkg::SLOT_W-1:0]       slot_id_o,
  output logic [srbm_pkg::ADDR_W-1:0]       buffer_offset_o,
  output logic [srbm_pkg::SIZE_W-1:0]       span_length_o,
  output logic [srbm_pkg::STREAM_W-1:0]     stream_offset_o,
  output logic [srbm_pkg::COUNT_W-1:0]      ready_count_o,
  output logic [srbm_pkg::COUNT_W-1:0]      free_count_o,
  // Configuration writes
  input  logic                              cfg_we_i,
  input  logic                              cfg_index_i,
  input  logic [srbm_pkg::SIZE_W-1:0]       cfg_data_i
);

  localparam int unsigned IdxW    = (MaxSlots > 1) ? $clog2(MaxSlots) : 1;
  localparam int unsigned CountW  = srbm_pkg::COUNT_W;
  localparam int unsigned CmpW    = ((IdxW > CountW) ? IdxW : CountW) + 1;
  localparam int unsigned AddrW   = srbm_pkg::ADDR_W;
  localparam int unsigned SizeW   = srbm_pkg::SIZE_W;
  localparam int unsigned StreamW = srbm_pkg::STREAM_W;
  localparam int unsigned SlotW   = srbm_pkg::SLOT_W;

  // Configuration registers.
  logic [CountW-1:0] slot_count_q;
  logic [SizeW-1:0]  slot_size_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_count_q <= srbm_pkg::SLOT_COUNT_RST;
      slot_size_q  <= srbm_pkg::SLOT_SIZE_RST;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        srbm_pkg::REG_SLOT_COUNT: slot_count_q <= cfg_data_i[CountW-1:0];
        srbm_pkg::REG_SLOT_SIZE:  slot_size_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Input register. It moves on whenever the result register is free or is
  // being emptied in the same cycle.
  logic                              in_valid_q;
  logic [srbm_pkg::FUNC_W-1:0]       func_q;
  logic [StreamW-1:0]                at_q;
  logic [SizeW-1:0]                  count_q;
  logic                              out_valid_q;
  logic                              advance;
  logic                              fire;

  assign advance    = !out_valid_q || out_ready_i;
  assign fire       = in_valid_q && advance;
  assign in_ready_o = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      func_q  <= func_i;
      at_q    <= at_offset_i;
      count_q <= byte_count_i;
    end
  end

  // Ring state.
  logic [IdxW-1:0]    write_index_q, write_index_d;
  logic [IdxW-1:0]    read_index_q, read_index_d;
  logic [CountW-1:0]  ready_slots_q, ready_slots_d;
  logic [SizeW-1:0]   read_position_q, read_position_d;
  logic [StreamW-1:0] running_q, running_d;

  // Descriptor table, read at the consumer slot.
  srbm_pkg::desc_cmd_t cmd, cmd_fire;
  logic [StreamW-1:0]  wr_offset;
  logic                rd_ready;
  logic [SizeW-1:0]    rd_length;
  logic [StreamW-1:0]  rd_offset;

  assign cmd_fire = fire ? cmd : '0;

  srbm_desc_table #(
    .MaxSlots (MaxSlots)
  ) u_desc_table (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd_fire),
    .wr_idx_i    (write_index_q),
    .wr_offset_i (wr_offset),
    .wr_length_i (count_q),
    .rd_idx_i    (read_index_q),
    .rd_ready_o  (rd_ready),
    .rd_length_o (rd_length),
    .rd_offset_o (rd_offset)
  );

  // Shared checks. The geometry is bad when the slot count or size is out of
  // range, or when more slots are ready than the ring now holds.
  logic              geom_bad;
  logic              wr_stale;
  logic              rd_stale;
  logic              ring_full;
  logic              rd_hard_bad;
  logic              rd_not_ready;
  logic              rd_inconsistent;
  logic [CmpW-1:0]   wr_inc;
  logic [CmpW-1:0]   rd_inc;
  logic [IdxW-1:0]   wr_next;
  logic [IdxW-1:0]   rd_next;
  logic [SizeW-1:0]  rd_remain;
  logic [AddrW-1:0]  wr_base;
  logic [AddrW-1:0]  rd_base;
  srbm_pkg::status_e commit_status;
  srbm_pkg::status_e peek_status;
  srbm_pkg::status_e release_status;

  always_comb begin
    geom_bad = (slot_count_q == '0) || (CmpW'(slot_count_q) > CmpW'(MaxSlots)) ||
               (slot_size_q == '0) || (ready_slots_q > slot_count_q);
    wr_stale  = CmpW'(write_index_q) >= CmpW'(slot_count_q);
    rd_stale  = CmpW'(read_index_q) >= CmpW'(slot_count_q);
    ring_full = ready_slots_q >= slot_count_q;

    wr_inc  = CmpW'(write_index_q) + CmpW'(1);
    rd_inc  = CmpW'(read_index_q) + CmpW'(1);
    wr_next = (wr_inc >= CmpW'(slot_count_q)) ? '0 : IdxW'(wr_inc);
    rd_next = (rd_inc >= CmpW'(slot_count_q)) ? '0 : IdxW'(rd_inc);

    rd_remain = rd_length - read_position_q;
    wr_base   = AddrW'(write_index_q) * AddrW'(slot_size_q);
    rd_base   = AddrW'(read_index_q) * AddrW'(slot_size_q);

    if (geom_bad || wr_stale) begin
      commit_status = srbm_pkg::ST_INVALID;
    end else if (ring_full) begin
      commit_status = srbm_pkg::ST_FULL;
    end else if ((count_q == '0) || (count_q > slot_size_q)) begin
      commit_status = srbm_pkg::ST_TOO_LARGE;
    end else begin
      commit_status = srbm_pkg::ST_OK;
    end

    // A slot that is not ready reads as empty to a peek but is an error for
    // a release.
    rd_hard_bad     = geom_bad || rd_stale;
    rd_not_ready    = !rd_ready || (rd_length == '0);
    rd_inconsistent = (rd_length > slot_size_q) || (read_position_q >= rd_length);
    if (rd_hard_bad) begin
      peek_status    = srbm_pkg::ST_INVALID;
      release_status = srbm_pkg::ST_INVALID;
    end else if (ready_slots_q == '0) begin
      peek_status    = srbm_pkg::ST_EMPTY;
      release_status = srbm_pkg::ST_EMPTY;
    end else if (rd_not_ready) begin
      peek_status    = srbm_pkg::ST_EMPTY;
      release_status = srbm_pkg::ST_INVALID;
    end else if (rd_inconsistent) begin
      peek_status    = srbm_pkg::ST_INVALID;
      release_status = srbm_pkg::ST_INVALID;
    end else begin
      peek_status    = srbm_pkg::ST_OK;
      release_status = srbm_pkg::ST_OK;
    end
  end

  // Execute the operation held in the input register.
  srbm_pkg::status_e res_status;
  logic [IdxW-1:0]   res_idx;
  logic [AddrW-1:0]  res_boff;
  logic [SizeW-1:0]  res_span;
  logic [StreamW-1:0] res_soff;
  logic [CountW-1:0] res_free;
  logic              do_release;

  always_comb begin
    res_status      = srbm_pkg::ST_OK;
    res_idx         = '0;
    res_boff        = '0;
    res_span        = '0;
    res_soff        = '0;
    cmd             = '0;
    do_release      = 1'b0;
    wr_offset       = running_q;
    write_index_d   = write_index_q;
    read_index_d    = read_index_q;
    ready_slots_d   = ready_slots_q;
    read_position_d = read_position_q;
    running_d       = running_q;

    case (func_q)
      srbm_pkg::FN_ACQUIRE: begin
        if (geom_bad) begin
          res_status = srbm_pkg::ST_INVALID;
        end else if (ring_full) begin
          res_status = srbm_pkg::ST_FULL;
          res_idx    = write_index_q;
        end else begin
          res_idx  = write_index_q;
          res_boff = wr_base;
          res_span = slot_size_q;
        end
      end
      srbm_pkg::FN_COMMIT, srbm_pkg::FN_COMMIT_AT: begin
        if (func_q == srbm_pkg::FN_COMMIT_AT) begin
          wr_offset = at_q;
        end
        res_status = commit_status;
        if (commit_status == srbm_pkg::ST_OK) begin
          cmd.commit    = 1'b1;
          running_d     = wr_offset + StreamW'(count_q);
          write_index_d = wr_next;
          ready_slots_d = ready_slots_q + CountW'(1);
        end
      end
      srbm_pkg::FN_PEEK: begin
        res_status = peek_status;
        if (peek_status == srbm_pkg::ST_OK) begin
          res_idx  = read_index_q;
          res_boff = rd_base + AddrW'(read_position_q);
          res_span = rd_remain;
          res_soff = rd_offset + StreamW'(read_position_q);
        end
      end
      srbm_pkg::FN_RELEASE: begin
        res_status = release_status;
        do_release = (release_status == srbm_pkg::ST_OK);
      end
      srbm_pkg::FN_RELEASE_BYTES: begin
        // A zero-byte release is always accepted and changes nothing.
        if (count_q != '0) begin
          res_status = release_status;
          if (release_status == srbm_pkg::ST_OK) begin
            if (count_q > rd_remain) begin
              res_status = srbm_pkg::ST_TOO_LARGE;
            end else if (count_q < rd_remain) begin
              read_position_d = read_position_q + count_q;
            end else begin
              do_release = 1'b1;
            end
          end
        end
      end
      srbm_pkg::FN_CLEAR: begin
        cmd.clear       = 1'b1;
        write_index_d   = '0;
        read_index_d    = '0;
        ready_slots_d   = '0;
        read_position_d = '0;
        running_d       = '0;
      end
      default: begin
        res_status = srbm_pkg::ST_INVALID;
      end
    endcase

    if (do_release) begin
      cmd.release_slot = 1'b1;
      read_position_d  = '0;
      read_index_d     = rd_next;
      ready_slots_d    = ready_slots_q - CountW'(1);
    end

    res_free = (ready_slots_d > slot_count_q) ? '0 : slot_count_q - ready_slots_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      write_index_q   <= '0;
      read_index_q    <= '0;
      ready_slots_q   <= '0;
      read_position_q <= '0;
      running_q       <= '0;
    end else if (fire) begin
      write_index_q   <= write_index_d;
      read_index_q    <= read_index_d;
      ready_slots_q   <= ready_slots_d;
      read_position_q <= read_position_d;
      running_q       <= running_d;
    end
  end

  // Result register.
  logic [srbm_pkg::STATUS_W-1:0] status_q;
  logic [SlotW-1:0]              slot_id_q;
  logic [AddrW-1:0]              buffer_offset_q;
  logic [SizeW-1:0]              span_length_q;
  logic [StreamW-1:0]            stream_offset_q;
  logic [CountW-1:0]             ready_count_q;
  logic [CountW-1:0]             free_count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      status_q        <= res_status;
      slot_id_q       <= SlotW'(res_idx);
      buffer_offset_q <= res_boff;
      span_length_q   <= res_span;
      stream_offset_q <= res_soff;
      ready_count_q   <= ready_slots_d;
      free_count_q    <= res_free;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign status_o        = status_q;
  assign slot_id_o       = slot_id_q;
  assign buffer_offset_o = buffer_offset_q;
  assign span_length_o   = span_length_q;
  assign stream_offset_o = stream_offset_q;
  assign ready_count_o   = ready_count_q;
  assign free_count_o    = free_count_q;

  // A failed operation leaves the ring pointers and the ready count alone.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && (res_status != srbm_pkg::ST_OK) |=>
      $stable(ready_slots_q) && $stable(write_index_q) && $stable(read_index_q))
    else $error("ring state changed on a failed operation");

  // A successful commit adds exactly one ready slot.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && (res_status == srbm_pkg::ST_OK) &&
      ((func_q == srbm_pkg::FN_COMMIT) || (func_q == srbm_pkg::FN_COMMIT_AT)) |=>
      ready_slots_q == $past(ready_slots_q) + CountW'(1))
    else $error("commit did not add one ready slot");

  // A partly read slot is still marked ready. Its length may have been
  // rewritten by a commit after the ring was resized, so only the flag holds.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (read_position_q != '0) |-> rd_ready)
    else $error("read position outside a ready slot");

endmodule
